/* design/assert_macros.svh */
// assertion macros shared by the parser rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed: required property violated");

// expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("assertion failed: forbidden condition seen");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)

`endif

`endif

/* design/ll1p_pkg.sv */
// shared constants, codes and grammar tables for the ll1 expression parser
package ll1p_pkg;

  localparam int STACK_DEPTH_DEFAULT = 64;

  localparam int SYM_W    = 4;
  localparam int TOK_W    = 3;
  localparam int PROD_W   = 4;
  localparam int ROW_W    = 24;
  localparam int NUM_ROWS = 5;
  localparam int CFG_IDX_W = 3;

  // token codes, also terminal symbol codes
  localparam logic [TOK_W-1:0] TOK_I     = 3'd0;
  localparam logic [TOK_W-1:0] TOK_PLUS  = 3'd1;
  localparam logic [TOK_W-1:0] TOK_STAR  = 3'd2;
  localparam logic [TOK_W-1:0] TOK_OPEN  = 3'd3;
  localparam logic [TOK_W-1:0] TOK_CLOSE = 3'd4;
  localparam logic [TOK_W-1:0] TOK_END   = 3'd5;

  // stack symbols
  localparam logic [SYM_W-1:0] SYM_I     = 4'd0;
  localparam logic [SYM_W-1:0] SYM_PLUS  = 4'd1;
  localparam logic [SYM_W-1:0] SYM_STAR  = 4'd2;
  localparam logic [SYM_W-1:0] SYM_OPEN  = 4'd3;
  localparam logic [SYM_W-1:0] SYM_CLOSE = 4'd4;
  localparam logic [SYM_W-1:0] SYM_END   = 4'd5;
  localparam logic [SYM_W-1:0] SYM_E     = 4'd8;
  localparam logic [SYM_W-1:0] SYM_K     = 4'd9;
  localparam logic [SYM_W-1:0] SYM_T     = 4'd10;
  localparam logic [SYM_W-1:0] SYM_M     = 4'd11;
  localparam logic [SYM_W-1:0] SYM_F     = 4'd12;

  // production numbers
  localparam logic [PROD_W-1:0] PROD_NONE  = 4'd0;
  localparam logic [PROD_W-1:0] PROD_E_TK  = 4'd1;
  localparam logic [PROD_W-1:0] PROD_K_PTK = 4'd2;
  localparam logic [PROD_W-1:0] PROD_K_EPS = 4'd3;
  localparam logic [PROD_W-1:0] PROD_T_FM  = 4'd4;
  localparam logic [PROD_W-1:0] PROD_M_SFM = 4'd5;
  localparam logic [PROD_W-1:0] PROD_M_EPS = 4'd6;
  localparam logic [PROD_W-1:0] PROD_F_PAR = 4'd7;
  localparam logic [PROD_W-1:0] PROD_F_I   = 4'd8;

  // verdict codes
  localparam logic [1:0] VERDICT_PENDING = 2'd0;
  localparam logic [1:0] VERDICT_ACCEPT  = 2'd1;
  localparam logic [1:0] VERDICT_REJECT  = 2'd2;

  // standard parse table rows after reset
  localparam logic [ROW_W-1:0] ROW_RESET [NUM_ROWS] = '{
    24'd4097, 24'd3342368, 24'd16388, 24'd6686048, 24'd28680
  };

  function automatic logic prod_ok(input logic [PROD_W-1:0] prod);
    return (prod != PROD_NONE) && (prod <= PROD_F_I);
  endfunction

  // number of right-hand-side symbols
  function automatic logic [1:0] rhs_len(input logic [PROD_W-1:0] prod);
    logic [1:0] len;
    unique case (prod)
      PROD_E_TK, PROD_T_FM:   len = 2'd2;
      PROD_K_PTK, PROD_M_SFM,
      PROD_F_PAR:             len = 2'd3;
      PROD_F_I:               len = 2'd1;
      default:                len = 2'd0;
    endcase
    return len;
  endfunction

  // right-hand-side symbol at position idx, leftmost at 0
  function automatic logic [SYM_W-1:0] rhs_sym(input logic [PROD_W-1:0] prod,
                                               input logic [1:0] idx);
    logic [SYM_W-1:0] sym;
    sym = SYM_I;
    unique case (prod)
      PROD_E_TK:  sym = (idx == 2'd0) ? SYM_T : SYM_K;
      PROD_K_PTK: sym = (idx == 2'd0) ? SYM_PLUS : ((idx == 2'd1) ? SYM_T : SYM_K);
      PROD_T_FM:  sym = (idx == 2'd0) ? SYM_F : SYM_M;
      PROD_M_SFM: sym = (idx == 2'd0) ? SYM_STAR : ((idx == 2'd1) ? SYM_F : SYM_M);
      PROD_F_PAR: sym = (idx == 2'd0) ? SYM_OPEN : ((idx == 2'd1) ? SYM_E : SYM_CLOSE);
      default:    sym = SYM_I;
    endcase
    return sym;
  endfunction

endpackage

/* design/ll1p_stack_ram.sv */
// symbol stack storage, one write and one registered read port
module ll1p_stack_ram #(
  parameter int DEPTH = ll1p_pkg::STACK_DEPTH_DEFAULT,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [AW-1:0]              waddr_i,
  input  logic [ll1p_pkg::SYM_W-1:0] wdata_i,
  input  logic [AW-1:0]              raddr_i,
  output logic [ll1p_pkg::SYM_W-1:0] rdata_o
);

  logic [ll1p_pkg::SYM_W-1:0] mem [DEPTH];
  logic [ll1p_pkg::SYM_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* design/ll1p_cfg_regs.sv */
// parse table registers and production lookup
module ll1p_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic [ll1p_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ll1p_pkg::ROW_W-1:0]     cfg_data_i,
  input  logic [2:0]                     nt_i,
  input  logic [ll1p_pkg::TOK_W-1:0]     col_i,
  output logic [ll1p_pkg::PROD_W-1:0]    prod_o
);

  logic [ll1p_pkg::ROW_W-1:0] rows_q [ll1p_pkg::NUM_ROWS];
  logic [ll1p_pkg::ROW_W-1:0] row;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= ll1p_pkg::ROW_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        3'd0:    rows_q[0] <= cfg_data_i;
        3'd1:    rows_q[1] <= cfg_data_i;
        3'd2:    rows_q[2] <= cfg_data_i;
        3'd3:    rows_q[3] <= cfg_data_i;
        3'd4:    rows_q[4] <= cfg_data_i;
        default: ;  // writes past the table are dropped
      endcase
    end
  end

  // an unknown nonterminal reads as an empty row, i.e. an error entry
  always_comb begin
    unique case (nt_i)
      3'd0:    row = rows_q[0];
      3'd1:    row = rows_q[1];
      3'd2:    row = rows_q[2];
      3'd3:    row = rows_q[3];
      3'd4:    row = rows_q[4];
      default: row = '0;
    endcase
  end

  always_comb begin
    unique case (col_i)
      3'd1:    prod_o = row[7:4];
      3'd2:    prod_o = row[11:8];
      3'd3:    prod_o = row[15:12];
      3'd4:    prod_o = row[19:16];
      3'd5:    prod_o = row[23:20];
      default: prod_o = row[3:0];
    endcase
  end

endmodule

/* design/ll1_expression_parser.sv */
// ll1 predictive parser for E->TK K->+TK|eps T->FM M->*FM|eps F->(E)|i
//
// input channel: in_valid_i / in_stall_o with token_i, one token per word,
// the end-marker token closes a string. output channel: out_valid_o /
// out_stall_i with verdict_o and overflow_o, exactly one word per token.
// verdict is pending for every token but the end marker, which gives accept
// or reject and restarts the parser for the next string.
// config channel: cfg_valid_i / cfg_ready_o with cfg_index_i and cfg_data_i
// writes one of the five parse table rows (E, K, T, M, F); write only while idle.
// sequencing: one token is worked at a time by a sequencer around a single
// table lookup and a stack ram with one write and one read port. a token
// is accepted, expanded once per nonterminal, with an extra push step for
// each 3-symbol production and a ram read for each pop that reads the ram,
// matched, and then loaded into the output register.
// the output register holds its word while out_stall_i is high; a finished
// result waits there while the next token is taken, and the sequencer only
// waits when a second result is ready before the first has gone.
// reset: table rows take the standard table, stack holds end marker and E,
// error and overflow flags clear, no output word is valid.
module ll1_expression_parser #(
  parameter int STACK_DEPTH = ll1p_pkg::STACK_DEPTH_DEFAULT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [ll1p_pkg::TOK_W-1:0]     token_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [1:0]                     verdict_o,
  output logic                           overflow_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [ll1p_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ll1p_pkg::ROW_W-1:0]     cfg_data_i
);

`include "assert_macros.svh"

  localparam int AW           = $clog2(STACK_DEPTH);
  localparam int SPW          = $clog2(STACK_DEPTH + 1);
  localparam int EXPAND_LIMIT = 2 * STACK_DEPTH + 16;
  localparam int CW           = $clog2(EXPAND_LIMIT + 1);

  typedef enum logic [2:0] {
    ST_IDLE,      // waiting for a token
    ST_EXPAND,    // expand nonterminal on top or match terminal
    ST_PUSH,      // second ram push of a 3-symbol production
    ST_READ_EXP,  // new top arrives from ram, keep expanding
    ST_READ_POP,  // new top arrives from ram after a match
    ST_RESP       // hand the verdict to the output register
  } state_e;

  state_e                      state_q, state_d;
  logic [SPW-1:0]              sp_q, sp_d;      // entries in use, top included
  logic [ll1p_pkg::SYM_W-1:0]  top_q, top_d;    // top of stack, kept out of ram
  logic                        err_q, err_d;
  logic                        ovf_q, ovf_d;
  logic [CW-1:0]               cnt_q, cnt_d;    // expansions for this token
  logic [ll1p_pkg::TOK_W-1:0]  tok_q, tok_d;
  logic [ll1p_pkg::TOK_W-1:0]  col_q, col_d;
  logic [ll1p_pkg::PROD_W-1:0] prod_q, prod_d;
  logic [1:0]                  res_verdict_q, res_verdict_d;
  logic                        res_ovf_q, res_ovf_d;
  logic                        out_valid_q, out_valid_d;
  logic [1:0]                  verdict_q, verdict_d;
  logic                        out_ovf_q, out_ovf_d;

  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [ll1p_pkg::SYM_W-1:0]  ram_wdata;
  logic [AW-1:0]               ram_raddr;
  logic [ll1p_pkg::SYM_W-1:0]  ram_rdata;

  logic [ll1p_pkg::PROD_W-1:0] prod;
  logic [1:0]                  len;
  logic [SPW:0]                need;
  logic                        top_is_nt;
  logic                        fail;
  logic                        fail_ovf;
  logic                        restart;

  ll1p_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .nt_i        (top_q[2:0]),
    .col_i       (col_q),
    .prod_o      (prod)
  );

  ll1p_stack_ram #(
    .DEPTH (STACK_DEPTH),
    .AW    (AW)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign verdict_o   = verdict_q;
  assign overflow_o  = out_ovf_q;

  assign len       = ll1p_pkg::rhs_len(prod);
  assign top_is_nt = top_q[3];
  // stack size after replacing the top by the right-hand side
  assign need      = {1'b0, sp_q} - (SPW+1)'(1) + (SPW+1)'(len);

  always_comb begin
    state_d       = state_q;
    sp_d          = sp_q;
    top_d         = top_q;
    err_d         = err_q;
    ovf_d         = ovf_q;
    cnt_d         = cnt_q;
    tok_d         = tok_q;
    col_d         = col_q;
    prod_d        = prod_q;
    res_verdict_d = res_verdict_q;
    res_ovf_d     = res_ovf_q;
    out_valid_d   = out_valid_q & out_stall_i;
    verdict_d     = verdict_q;
    out_ovf_d     = out_ovf_q;
    ram_we        = 1'b0;
    ram_waddr     = AW'(sp_q - SPW'(1));
    ram_wdata     = ll1p_pkg::rhs_sym(prod, 2'd2);
    ram_raddr     = AW'(sp_q - SPW'(2));
    fail          = 1'b0;
    fail_ovf      = 1'b0;
    restart       = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          tok_d = token_i;
          col_d = (token_i <= ll1p_pkg::TOK_END) ? token_i : ll1p_pkg::TOK_I;
          cnt_d = '0;
          if (err_q) begin
            // sticky error: skip the token, end marker closes with reject
            state_d = ST_RESP;
            if (token_i == ll1p_pkg::TOK_END) begin
              res_verdict_d = ll1p_pkg::VERDICT_REJECT;
              res_ovf_d     = ovf_q;
              restart       = 1'b1;
            end else begin
              res_verdict_d = ll1p_pkg::VERDICT_PENDING;
              res_ovf_d     = 1'b0;
            end
          end else begin
            state_d = ST_EXPAND;
          end
        end
      end

      ST_EXPAND: begin
        if (!top_is_nt) begin
          // terminal on top: match the token or give the final verdict
          state_d = ST_RESP;
          if (tok_q == ll1p_pkg::TOK_END) begin
            res_verdict_d = (top_q == ll1p_pkg::SYM_END) ? ll1p_pkg::VERDICT_ACCEPT
                                                          : ll1p_pkg::VERDICT_REJECT;
            res_ovf_d     = 1'b0;
            restart       = 1'b1;
          end else if (top_q == {1'b0, tok_q}) begin
            res_verdict_d = ll1p_pkg::VERDICT_PENDING;
            res_ovf_d     = 1'b0;
            sp_d          = sp_q - SPW'(1);
            if (sp_q == SPW'(2)) begin
              top_d = ll1p_pkg::SYM_END;
            end else begin
              state_d = ST_READ_POP;
            end
          end else begin
            fail = 1'b1;
          end
        end else if (top_q > ll1p_pkg::SYM_F || cnt_q >= CW'(EXPAND_LIMIT) ||
                     !ll1p_pkg::prod_ok(prod)) begin
          fail = 1'b1;
        end else if (need > (SPW+1)'(STACK_DEPTH)) begin
          fail     = 1'b1;
          fail_ovf = 1'b1;
        end else begin
          cnt_d = cnt_q + CW'(1);
          unique case (len)
            2'd0: begin
              // epsilon: pop, the entry below is the new top
              sp_d = sp_q - SPW'(1);
              if (sp_q == SPW'(2)) begin
                top_d = ll1p_pkg::SYM_END;
              end else begin
                state_d = ST_READ_EXP;
              end
            end
            2'd1: begin
              top_d = ll1p_pkg::rhs_sym(prod, 2'd0);
            end
            2'd2: begin
              ram_we    = 1'b1;
              ram_wdata = ll1p_pkg::rhs_sym(prod, 2'd1);
              top_d     = ll1p_pkg::rhs_sym(prod, 2'd0);
              sp_d      = sp_q + SPW'(1);
            end
            default: begin
              // rightmost symbol now, middle one next cycle
              ram_we    = 1'b1;
              ram_wdata = ll1p_pkg::rhs_sym(prod, 2'd2);
              sp_d      = sp_q + SPW'(1);
              prod_d    = prod;
              state_d   = ST_PUSH;
            end
          endcase
        end
      end

      ST_PUSH: begin
        ram_we    = 1'b1;
        ram_wdata = ll1p_pkg::rhs_sym(prod_q, 2'd1);
        top_d     = ll1p_pkg::rhs_sym(prod_q, 2'd0);
        sp_d      = sp_q + SPW'(1);
        state_d   = ST_EXPAND;
      end

      ST_READ_EXP: begin
        top_d   = ram_rdata;
        state_d = ST_EXPAND;
      end

      ST_READ_POP: begin
        top_d   = ram_rdata;
        state_d = ST_RESP;
      end

      ST_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          verdict_d   = res_verdict_q;
          out_ovf_d   = res_ovf_q;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // failure while settling or matching
    if (fail) begin
      state_d = ST_RESP;
      if (tok_q == ll1p_pkg::TOK_END) begin
        res_verdict_d = ll1p_pkg::VERDICT_REJECT;
        res_ovf_d     = ovf_q | fail_ovf;
        restart       = 1'b1;
      end else begin
        err_d         = 1'b1;
        ovf_d         = ovf_q | fail_ovf;
        res_verdict_d = ll1p_pkg::VERDICT_PENDING;
        res_ovf_d     = 1'b0;
      end
    end

    // back to end marker plus E for the next string
    if (restart) begin
      sp_d  = SPW'(2);
      top_d = ll1p_pkg::SYM_E;
      err_d = 1'b0;
      ovf_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      sp_q          <= SPW'(2);
      top_q         <= ll1p_pkg::SYM_E;
      err_q         <= 1'b0;
      ovf_q         <= 1'b0;
      cnt_q         <= '0;
      tok_q         <= ll1p_pkg::TOK_I;
      col_q         <= ll1p_pkg::TOK_I;
      prod_q        <= ll1p_pkg::PROD_NONE;
      res_verdict_q <= ll1p_pkg::VERDICT_PENDING;
      res_ovf_q     <= 1'b0;
      out_valid_q   <= 1'b0;
      verdict_q     <= ll1p_pkg::VERDICT_PENDING;
      out_ovf_q     <= 1'b0;
    end else begin
      state_q       <= state_d;
      sp_q          <= sp_d;
      top_q         <= top_d;
      err_q         <= err_d;
      ovf_q         <= ovf_d;
      cnt_q         <= cnt_d;
      tok_q         <= tok_d;
      col_q         <= col_d;
      prod_q        <= prod_d;
      res_verdict_q <= res_verdict_d;
      res_ovf_q     <= res_ovf_d;
      out_valid_q   <= out_valid_d;
      verdict_q     <= verdict_d;
      out_ovf_q     <= out_ovf_d;
    end
  end

  // the end marker at the bottom is never popped and the stack never grows past depth
  `ASSERT_ALWAYS(a_sp_range, clk_i, rst_ni, (sp_q != '0) && (sp_q <= SPW'(STACK_DEPTH)))
  // a taken token leaves the sequencer busy in the cycle after it is taken
  `ASSERT_ALWAYS(a_busy_after_take, clk_i, rst_ni, (in_valid_i && !in_stall_o) |=> in_stall_o)
  // overflow is only reported together with a reject
  `ASSERT_ALWAYS(a_ovf_reject, clk_i, rst_ni,
                 (out_valid_o && overflow_o) |-> (verdict_o == ll1p_pkg::VERDICT_REJECT))
  // the bottom entry lives outside the ram and is never written
  `ASSERT_NEVER(a_no_bottom_write, clk_i, rst_ni, ram_we && (ram_waddr == '0))

endmodule
